[rtl/core/bdot_detumble_controller_top_defines.svh]
// assertion macros for the bdot detumble controller
`ifndef BDOT_DETUMBLE_CONTROLLER_TOP_DEFINES_SVH
`define BDOT_DETUMBLE_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BDOT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bdot assertion failed");
`define BDOT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bdot assertion failed");
`else
`define BDOT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BDOT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/bdot_pkg.sv]
`timescale 1ns / 1ps
package bdot_pkg;
	localparam int B_W     = 18;
	localparam int W_W     = 16;
	localparam int M_W     = 16;
	localparam int TQ_W    = 36;
	localparam int GAIN_W  = 32;
	localparam int LIM_W   = 15;
	localparam int FLOOR_W = 36;
	localparam int CFG_W   = 36;
	localparam int IDX_W   = 2;

	localparam int WB_W    = B_W + W_W;
	localparam int CR_W    = WB_W + 1;
	localparam int SQ_W    = 2 * B_W - 1;
	localparam int HALF_W  = GAIN_W / 2;
	localparam int PP_W    = CR_W + HALF_W + 1;
	localparam int FULL_W  = PP_W + HALF_W;
	localparam int FRAC_SHIFT = 42;
	localparam int MR_W    = FULL_W - FRAC_SHIFT;
	localparam int MB_W    = M_W + B_W;
	localparam int STAGES  = 7;

	localparam logic [GAIN_W-1:0]  GAIN_RST  = '0;
	localparam logic [LIM_W-1:0]   LIM_RST   = LIM_W'(1024);
	localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_W'(1000000);

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN  = 2'd0,
		REG_LIMIT = 2'd1,
		REG_FLOOR = 2'd2
	} cfg_reg_t;
endpackage

[rtl/core/bdot_detumble_controller_top.sv]
`timescale 1ns / 1ps
// b-dot detumble controller
// in channel (in_valid/in_ready) takes one item: field b_x/b_y/b_z and body
// rate w_x/w_y/w_z. out channel (out_valid/out_ready) gives one item per input:
// clipped dipole m_x/m_y/m_z, torque tq_x/tq_y/tq_z and weak_field.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes gain (0),
// dipole_limit (1) and field_floor_sq (2); other indexes are ignored.
// cfg_ready is always high; write only while no item is in flight.
// throughput is one item per cycle while out_ready is high, set by a 7 stage
// pipeline: products, cross product and field check, gain multiply in two
// 16 bit halves, floor shift, clip, torque products, torque difference.
// each stage holds its item while the next is full, so bubbles close up and
// a new item is still taken while a finished one waits at the output.
// a stalled receiver loses and repeats nothing.
// reset empties the pipeline and loads gain 0, dipole_limit 1024,
// field_floor_sq 1000000.
`include "bdot_detumble_controller_top_defines.svh"
module bdot_detumble_controller_top
	import bdot_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [B_W-1:0]   b_x,
	input  logic signed [B_W-1:0]   b_y,
	input  logic signed [B_W-1:0]   b_z,
	input  logic signed [W_W-1:0]   w_x,
	input  logic signed [W_W-1:0]   w_y,
	input  logic signed [W_W-1:0]   w_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [M_W-1:0]   m_x,
	output logic signed [M_W-1:0]   m_y,
	output logic signed [M_W-1:0]   m_z,
	output logic signed [TQ_W-1:0]  tq_x,
	output logic signed [TQ_W-1:0]  tq_y,
	output logic signed [TQ_W-1:0]  tq_z,
	output logic                    weak_field
);

	logic [GAIN_W-1:0]  gain_q;
	logic [LIM_W-1:0]   dipole_limit_q;
	logic [FLOOR_W-1:0] floor_q;

	logic [STAGES:1] vld_q;
	logic [STAGES:1] en;

	logic signed [B_W-1:0]   b_in [3];
	logic signed [W_W-1:0]   w_in [3];

	logic signed [WB_W-1:0]  pa_s1 [3];
	logic signed [WB_W-1:0]  pb_s1 [3];
	logic [SQ_W-1:0]         sq_s1 [3];
	logic signed [B_W-1:0]   b_s1  [3];

	logic signed [CR_W-1:0]  c_s2  [3];
	logic                    weak_s2;
	logic signed [B_W-1:0]   b_s2  [3];

	logic signed [PP_W-1:0]  ph_s3 [3];
	logic signed [PP_W-1:0]  pl_s3 [3];
	logic                    weak_s3;
	logic signed [B_W-1:0]   b_s3  [3];

	logic signed [MR_W-1:0]  mr_s4 [3];
	logic                    weak_s4;
	logic signed [B_W-1:0]   b_s4  [3];

	logic signed [M_W-1:0]   m_s5  [3];
	logic                    weak_s5;
	logic signed [B_W-1:0]   b_s5  [3];

	logic signed [MB_W-1:0]  ta_s6 [3];
	logic signed [MB_W-1:0]  tb_s6 [3];
	logic signed [M_W-1:0]   m_s6  [3];
	logic                    weak_s6;

	logic signed [TQ_W-1:0]  tq_s7 [3];
	logic signed [M_W-1:0]   m_s7  [3];
	logic                    weak_s7;

	logic signed [2*B_W-1:0] sq_full [3];
	logic [FLOOR_W-1:0]      nsq;
	logic signed [FULL_W-1:0] full [3];
	logic signed [MR_W-1:0]  lim_pos;
	logic signed [MR_W-1:0]  lim_neg;
	logic signed [MR_W-1:0]  clip [3];
	logic signed [M_W-1:0]   lim16;

	assign b_in = '{b_x, b_y, b_z};
	assign w_in = '{w_x, w_y, w_z};

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q         <= GAIN_RST;
			dipole_limit_q <= LIM_RST;
			floor_q        <= FLOOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN:  gain_q         <= cfg_data[GAIN_W-1:0];
				REG_LIMIT: dipole_limit_q <= cfg_data[LIM_W-1:0];
				REG_FLOOR: floor_q        <= cfg_data[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	// per stage flow control
	always_comb begin
		en[STAGES] = !vld_q[STAGES] || out_ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// combinational pieces between stages
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_full[i] = (2*B_W)'(b_in[i]) * (2*B_W)'(b_in[i]);
		end
		nsq = {1'b0, sq_s1[0]} + {1'b0, sq_s1[1]} + {1'b0, sq_s1[2]};
		for (int i = 0; i < 3; i++) begin
			full[i] = (FULL_W'(ph_s3[i]) <<< HALF_W) + FULL_W'(pl_s3[i]);
		end
		lim_pos = $signed(MR_W'(dipole_limit_q));
		lim_neg = -lim_pos;
		for (int i = 0; i < 3; i++) begin
			if (mr_s4[i] > lim_pos) begin
				clip[i] = lim_pos;
			end else if (mr_s4[i] < lim_neg) begin
				clip[i] = lim_neg;
			end else begin
				clip[i] = mr_s4[i];
			end
		end
	end

	// stage 1: rate by field products and field squares
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pa_s1[0] <= WB_W'(w_in[1]) * WB_W'(b_in[2]);
			pb_s1[0] <= WB_W'(w_in[2]) * WB_W'(b_in[1]);
			pa_s1[1] <= WB_W'(w_in[2]) * WB_W'(b_in[0]);
			pb_s1[1] <= WB_W'(w_in[0]) * WB_W'(b_in[2]);
			pa_s1[2] <= WB_W'(w_in[0]) * WB_W'(b_in[1]);
			pb_s1[2] <= WB_W'(w_in[1]) * WB_W'(b_in[0]);
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= sq_full[i][SQ_W-1:0];
				b_s1[i]  <= b_in[i];
			end
		end
	end

	// stage 2: cross product and field check
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= CR_W'(pa_s1[i]) - CR_W'(pb_s1[i]);
				b_s2[i] <= b_s1[i];
			end
			weak_s2 <= nsq < floor_q;
		end
	end

	// stage 3: gain multiply, upper and lower halves
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				ph_s3[i] <= PP_W'(c_s2[i])
					* PP_W'($signed({1'b0, gain_q[GAIN_W-1:HALF_W]}));
				pl_s3[i] <= PP_W'(c_s2[i])
					* PP_W'($signed({1'b0, gain_q[HALF_W-1:0]}));
				b_s3[i]  <= b_s2[i];
			end
			weak_s3 <= weak_s2;
		end
	end

	// stage 4: recombine and floor shift
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				mr_s4[i] <= full[i][FULL_W-1:FRAC_SHIFT];
				b_s4[i]  <= b_s3[i];
			end
			weak_s4 <= weak_s3;
		end
	end

	// stage 5: clip, weak field forces zero
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				m_s5[i] <= weak_s4 ? '0 : clip[i][M_W-1:0];
				b_s5[i] <= b_s4[i];
			end
			weak_s5 <= weak_s4;
		end
	end

	// stage 6: dipole by field products
	always_ff @(posedge clk) begin
		if (en[6]) begin
			ta_s6[0] <= MB_W'(m_s5[1]) * MB_W'(b_s5[2]);
			tb_s6[0] <= MB_W'(m_s5[2]) * MB_W'(b_s5[1]);
			ta_s6[1] <= MB_W'(m_s5[2]) * MB_W'(b_s5[0]);
			tb_s6[1] <= MB_W'(m_s5[0]) * MB_W'(b_s5[2]);
			ta_s6[2] <= MB_W'(m_s5[0]) * MB_W'(b_s5[1]);
			tb_s6[2] <= MB_W'(m_s5[1]) * MB_W'(b_s5[0]);
			m_s6    <= m_s5;
			weak_s6 <= weak_s5;
		end
	end

	// stage 7: torque
	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int i = 0; i < 3; i++) begin
				tq_s7[i] <= TQ_W'(ta_s6[i]) - TQ_W'(tb_s6[i]);
			end
			m_s7    <= m_s6;
			weak_s7 <= weak_s6;
		end
	end

	assign out_valid  = vld_q[STAGES];
	assign m_x        = m_s7[0];
	assign m_y        = m_s7[1];
	assign m_z        = m_s7[2];
	assign tq_x       = tq_s7[0];
	assign tq_y       = tq_s7[1];
	assign tq_z       = tq_s7[2];
	assign weak_field = weak_s7;

	assign lim16 = $signed({1'b0, dipole_limit_q});

	`BDOT_ASSERT_IMP(a_weak_zero, clk, arst_n, out_valid && weak_field,
		m_x == '0 && m_y == '0 && m_z == '0 && tq_x == '0 && tq_y == '0 && tq_z == '0)
	`BDOT_ASSERT_IMP(a_dipole_in_limit, clk, arst_n, out_valid,
		m_x <= lim16 && m_x >= -lim16 && m_y <= lim16 && m_y >= -lim16
		&& m_z <= lim16 && m_z >= -lim16)
	`BDOT_ASSERT_NXT(a_limit_write, clk, arst_n, cfg_valid && cfg_index == REG_LIMIT,
		dipole_limit_q == $past(cfg_data[LIM_W-1:0]))
	`BDOT_ASSERT_NXT(a_stall_holds_inner, clk, arst_n,
		vld_q[STAGES] && !out_ready && vld_q[STAGES-1],
		vld_q[STAGES-1] && $stable(m_s6[0]) && $stable(ta_s6[0]))

endmodule

[tb/bdot_detumble_controller_top_tb.sv]
`timescale 1ns / 1ps
module bdot_detumble_controller_top_tb;
	import bdot_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 180;
	localparam longint B_MAX = (64'sd1 <<< (B_W - 1)) - 1;
	localparam longint B_MIN = -(64'sd1 <<< (B_W - 1));
	localparam longint W_MAX = (64'sd1 <<< (W_W - 1)) - 1;
	localparam longint W_MIN = -(64'sd1 <<< (W_W - 1));

	typedef struct {
		logic signed [B_W-1:0] b_x, b_y, b_z;
		logic signed [W_W-1:0] w_x, w_y, w_z;
	} sample_t;

	typedef struct {
		logic signed [M_W-1:0]  m_x, m_y, m_z;
		logic signed [TQ_W-1:0] tq_x, tq_y, tq_z;
		logic                   weak_field;
	} dipole_t;

	class dipole_scoreboard;
		logic [GAIN_W-1:0]  gain_r  = GAIN_RST;
		logic [LIM_W-1:0]   lim_r   = LIM_RST;
		logic [FLOOR_W-1:0] floor_r = FLOOR_RST;
		dipole_t pending_dipoles[$];
		int errors = 0;

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_GAIN:  gain_r  = data[GAIN_W-1:0];
				REG_LIMIT: lim_r   = data[LIM_W-1:0];
				REG_FLOOR: floor_r = data[FLOOR_W-1:0];
				default: ;
			endcase
		endfunction

		function dipole_t predict_dipole(sample_t s);
			longint bv[3], wv[3], cr[3], mv[3];
			longint nsq, lim;
			logic signed [69:0] prod;
			dipole_t r;
			r = '{default: 0};
			bv[0] = longint'(s.b_x);
			bv[1] = longint'(s.b_y);
			bv[2] = longint'(s.b_z);
			wv[0] = longint'(s.w_x);
			wv[1] = longint'(s.w_y);
			wv[2] = longint'(s.w_z);
			nsq = bv[0] * bv[0] + bv[1] * bv[1] + bv[2] * bv[2];
			if (nsq < longint'(floor_r)) begin
				r.weak_field = 1'b1;
				return r;
			end
			cr[0] = wv[1] * bv[2] - wv[2] * bv[1];
			cr[1] = wv[2] * bv[0] - wv[0] * bv[2];
			cr[2] = wv[0] * bv[1] - wv[1] * bv[0];
			lim = longint'(lim_r);
			for (int i = 0; i < 3; i++) begin
				prod = 70'($signed({1'b0, gain_r})) * 70'(cr[i]);
				mv[i] = longint'(prod >>> FRAC_SHIFT);
				if (mv[i] > lim)
					mv[i] = lim;
				else if (mv[i] < -lim)
					mv[i] = -lim;
			end
			r.m_x = M_W'(mv[0]);
			r.m_y = M_W'(mv[1]);
			r.m_z = M_W'(mv[2]);
			r.tq_x = TQ_W'(mv[1] * bv[2] - mv[2] * bv[1]);
			r.tq_y = TQ_W'(mv[2] * bv[0] - mv[0] * bv[2]);
			r.tq_z = TQ_W'(mv[0] * bv[1] - mv[1] * bv[0]);
			return r;
		endfunction

		function void note_sample(sample_t s);
			pending_dipoles.push_back(predict_dipole(s));
		endfunction

		function int pending();
			return pending_dipoles.size();
		endfunction

		function void cmp(string name, longint want, longint got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_dipole(dipole_t got);
			dipole_t want;
			if (pending_dipoles.size() == 0) begin
				$error("result item with no sample pending");
				errors++;
				return;
			end
			want = pending_dipoles.pop_front();
			cmp("m_x", longint'(want.m_x), longint'(got.m_x));
			cmp("m_y", longint'(want.m_y), longint'(got.m_y));
			cmp("m_z", longint'(want.m_z), longint'(got.m_z));
			cmp("tq_x", longint'(want.tq_x), longint'(got.tq_x));
			cmp("tq_y", longint'(want.tq_y), longint'(got.tq_y));
			cmp("tq_z", longint'(want.tq_z), longint'(got.tq_z));
			cmp("weak_field", longint'(want.weak_field), longint'(got.weak_field));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [B_W-1:0]  b_x, b_y, b_z;
	logic signed [W_W-1:0]  w_x, w_y, w_z;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [M_W-1:0]  m_x, m_y, m_z;
	logic signed [TQ_W-1:0] tq_x, tq_y, tq_z;
	logic                   weak_field;

	dipole_scoreboard sb;
	dipole_t seen;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;

	bdot_detumble_controller_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.w_x        (w_x),
		.w_y        (w_y),
		.w_z        (w_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.m_x        (m_x),
		.m_y        (m_y),
		.m_z        (m_z),
		.tq_x       (tq_x),
		.tq_y       (tq_y),
		.tq_z       (tq_z),
		.weak_field (weak_field)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sample_t mk(longint bx, longint by, longint bz,
			longint wx, longint wy, longint wz);
		sample_t s;
		s.b_x = B_W'(bx);
		s.b_y = B_W'(by);
		s.b_z = B_W'(bz);
		s.w_x = W_W'(wx);
		s.w_y = W_W'(wy);
		s.w_z = W_W'(wz);
		return s;
	endfunction

	// full range, extremes, zero, or a random magnitude
	function automatic longint rand_signed(int w);
		longint v;
		v = longint'({$urandom, $urandom}) >>> (64 - w);
		case ($urandom_range(0, 9))
			0: v = (64'sd1 <<< (w - 1)) - 1;
			1: v = -(64'sd1 <<< (w - 1));
			2: v = 0;
			3: ;
			default: v = v >>> $urandom_range(0, w - 1);
		endcase
		return v;
	endfunction

	function automatic sample_t rand_sample();
		return mk(rand_signed(B_W), rand_signed(B_W), rand_signed(B_W),
			rand_signed(W_W), rand_signed(W_W), rand_signed(W_W));
	endfunction

	task automatic send_item(sample_t s);
		@(negedge clk);
		b_x = s.b_x;
		b_y = s.b_y;
		b_z = s.b_z;
		w_x = s.w_x;
		w_y = s.w_y;
		w_z = s.w_z;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(s);
	endtask

	task automatic write_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk) cfg_valid = 1'b0;
	endtask

	task automatic drain();
		@(negedge clk) in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (STAGES + 2) @(posedge clk);
	endtask

	task automatic run_random(int n);
		int left;
		int burst;
		int gap;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && left > 0) begin
				send_item(rand_sample());
				burst--;
				left--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) @(negedge clk) in_valid = 1'b0;
		end
	endtask

	// receiver stall pattern, plus one long hold-off on request
	initial begin
		int mode;
		int len;
		out_ready = 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				repeat (HOLD_CYCLES) @(negedge clk) out_ready = 1'b0;
				hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				len = $urandom_range(1, 60);
				repeat (len) begin
					@(negedge clk);
					case (mode)
						0: out_ready = 1'b1;
						1: out_ready = 1'($urandom_range(0, 1));
						2: out_ready = ($urandom_range(0, 3) == 0);
						default: out_ready = ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen.m_x = m_x;
			seen.m_y = m_y;
			seen.m_z = m_z;
			seen.tq_x = tq_x;
			seen.tq_y = tq_y;
			seen.tq_z = tq_z;
			seen.weak_field = weak_field;
			sb.check_dipole(seen);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [GAIN_W-1:0]  g;
		logic [LIM_W-1:0]   lm;
		logic [FLOOR_W-1:0] fl;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_GAIN;
		cfg_data = '0;
		b_x = '0;
		b_y = '0;
		b_z = '0;
		w_x = '0;
		w_y = '0;
		w_z = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset values: floor edge exactly at 1000000
		send_item(mk(1000, 0, 0, 100, -200, 300));
		send_item(mk(999, 0, 0, 100, -200, 300));
		send_item(mk(0, -577, 816, W_MAX, W_MIN, 1));
		send_item(mk(B_MAX, B_MIN, B_MAX, W_MAX, W_MIN, W_MAX));
		drain();

		write_cfg(REG_GAIN, {(CFG_W - GAIN_W)'($urandom), {GAIN_W{1'b1}}});
		write_cfg(REG_LIMIT, {(CFG_W - LIM_W)'($urandom), {LIM_W{1'b1}}});
		write_cfg(REG_FLOOR, '0);
		write_cfg(REG_NONE, CFG_W'({$urandom, $urandom}));
		send_item(mk(0, 0, 0, 0, 0, 0));
		send_item(mk(B_MAX, B_MAX, B_MAX, W_MAX, W_MAX, W_MAX));
		send_item(mk(B_MIN, B_MIN, B_MIN, W_MIN, W_MIN, W_MIN));
		send_item(mk(B_MAX, B_MIN, B_MAX, W_MIN, W_MAX, W_MIN));
		send_item(mk(B_MIN, B_MAX, B_MIN, W_MAX, W_MIN, W_MAX));
		send_item(mk(1, 0, 0, 0, 1, 0));
		send_item(mk(1, 0, 0, 0, -1, 0));
		send_item(mk(0, 3, -5, 7, 0, -2));
		send_item(mk(-1, -1, -1, -1, -1, -1));
		drain();

		// zero clip: every dipole and torque axis is zero
		write_cfg(REG_LIMIT, '0);
		send_item(mk(B_MAX, B_MIN, B_MAX, W_MIN, W_MAX, W_MIN));
		send_item(mk(12345, -6789, 1011, -1213, 1415, -1617));
		drain();
		write_cfg(REG_LIMIT, {(CFG_W - LIM_W)'(0), LIM_W'(5)});
		write_cfg(REG_GAIN, {(CFG_W - GAIN_W)'(0), GAIN_W'(32'h0010_0000)});
		send_item(mk(B_MAX, 0, B_MIN, 0, W_MAX, 0));
		send_item(mk(-20000, 30000, 1500, 900, -4000, 250));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			g = $urandom >> $urandom_range(0, GAIN_W - 1);
			lm = LIM_W'($urandom) >> $urandom_range(0, LIM_W - 1);
			fl = FLOOR_W'({$urandom, $urandom}) >> $urandom_range(0, FLOOR_W - 1);
			case (p)
				0: begin
					g = '1;
					lm = '1;
					fl = '0;
				end
				1: lm = '0;
				2: fl = '1;
				3: g = '1;
				4: fl = FLOOR_RST;
				5: g = '0;
				default: ;
			endcase
			write_cfg(REG_GAIN, {(CFG_W - GAIN_W)'($urandom), g});
			write_cfg(REG_LIMIT, {(CFG_W - LIM_W)'($urandom), lm});
			write_cfg(REG_FLOOR, fl);
			if ($urandom_range(0, 1))
				write_cfg(REG_NONE, CFG_W'({$urandom, $urandom}));
			if (p == 3)
				hold_req = 1'b1;
			run_random(PHASE_ITEMS);
			drain();
		end

		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bdot_pkg.sv
rtl/core/bdot_detumble_controller_top.sv
tb/bdot_detumble_controller_top_tb.sv
